/* design/mf3rgb_pkg.sv */
// Shared types, constants and sorting helpers of the 3x3 RGB median filter.
`default_nettype none

package mf3rgb_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int WIN_SIZE  = 3;
   localparam int WIN_TAPS  = WIN_SIZE * WIN_SIZE;
   localparam int NUM_CHAN  = 3;
   localparam int CHAN_W    = 8;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int CFG_W     = 12;
   localparam int CNT_W     = CFG_W;
   localparam int CSR_IDX_W = 4;

   localparam logic [CFG_W-1:0] MIN_SIZE     = CFG_W'(3);
   localparam logic [CFG_W-1:0] WIDTH_LIMIT  = CFG_W'(MAX_WIDTH);
   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_W'(1);

   typedef logic [CHAN_W-1:0] chan_type;
   typedef chan_type [NUM_CHAN-1:0] pixel_type;
   typedef chan_type [WIN_TAPS-1:0] taps_type;

   typedef struct packed {
      logic     action;
      chan_type red_in;
      chan_type green_in;
      chan_type blue_in;
   } req_payload_type;

   typedef struct packed {
      chan_type red_out;
      chan_type green_out;
      chan_type blue_out;
      logic     end_of_line;
      logic     end_of_frame;
   } rsp_payload_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type lower;
   } line_pair_type;

   typedef struct packed {
      logic emit;
      logic border;
      logic eol;
      logic eof;
   } item_ctl_type;

   typedef struct packed {
      logic load_sort;
      logic load_reduce;
   } lane_ctl_type;

   typedef struct packed {
      chan_type lo;
      chan_type mid;
      chan_type hi;
   } triple_type;

   typedef triple_type [NUM_CHAN-1:0] lane_results_type;

   function automatic chan_type min2(chan_type a, chan_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic chan_type max2(chan_type a, chan_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic chan_type med3(chan_type a, chan_type b, chan_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic triple_type sort3(chan_type a, chan_type b, chan_type c);
      triple_type t;
      t.lo  = min2(min2(a, b), c);
      t.mid = med3(a, b, c);
      t.hi  = max2(max2(a, b), c);
      return t;
   endfunction

endpackage

`default_nettype wire

/* design/mf3rgb_line_buf.sv */
// Two line stores kept as one memory, read and written at the column address.
`default_nettype none

module mf3rgb_line_buf
   import mf3rgb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output line_pair_type      rd_data,
   input  wire logic          wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  line_pair_type      wr_data
);

   line_pair_type mem [MAX_WIDTH];
   line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/mf3rgb_lane.sv */
// One color lane: sorts the window columns, then reduces them to three candidates.
`default_nettype none

module mf3rgb_lane
   import mf3rgb_pkg::*;
(
   input  wire logic   clock,
   input  lane_ctl_type ctl,
   input  taps_type     taps,
   output triple_type   result
);

   triple_type [WIN_SIZE-1:0] cols_ff;
   triple_type [WIN_SIZE-1:0] cols_in;
   triple_type                result_ff;
   triple_type                result_in;

   always_comb begin
      for (int c = 0; c < WIN_SIZE; c++) begin
         cols_in[c] = sort3(taps[c], taps[WIN_SIZE + c], taps[2 * WIN_SIZE + c]);
      end
      result_in.lo  = max2(max2(cols_ff[0].lo, cols_ff[1].lo), cols_ff[2].lo);
      result_in.mid = med3(cols_ff[0].mid, cols_ff[1].mid, cols_ff[2].mid);
      result_in.hi  = min2(min2(cols_ff[0].hi, cols_ff[1].hi), cols_ff[2].hi);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_sort) begin
         cols_ff <= cols_in;
      end
      if (ctl.load_reduce) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

/* design/mf3rgb_merge.sv */
// Merging stage: final median per lane, border bypass and the output register.
`default_nettype none

module mf3rgb_merge
   import mf3rgb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       load,
   input  lane_results_type lanes,
   input  pixel_type        center,
   input  item_ctl_type     ctl,
   output rsp_payload_type  payload
);

   rsp_payload_type payload_ff;
   rsp_payload_type payload_in;
   pixel_type       med;

   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         med[ch] = ctl.border ? center[ch]
                              : med3(lanes[ch].lo, lanes[ch].mid, lanes[ch].hi);
      end
      payload_in.red_out      = med[2];
      payload_in.green_out    = med[1];
      payload_in.blue_out     = med[0];
      payload_in.end_of_line  = ctl.eol;
      payload_in.end_of_frame = ctl.eof;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= payload_in;
      end
   end

   assign payload = payload_ff;

endmodule

`default_nettype wire

/* design/median_filter_3x3_rgb.sv */
// Top level of the 3x3 RGB median filter with line stores and window.
//
//   Port group  Direction  Handshake              Contents
//   req_        in         req_valid / req_stall  action and one RGB pixel
//   rsp_        out        rsp_valid / rsp_stall  filtered pixel, line and frame ends
//   csr_        in         csr_valid / csr_ready  image width and height registers
//
// A request is taken at every clock edge that the result side does not hold back. Its
// result passes the stages line store read, column sort, reduce and merge. Requests that
// produce no result leave after the first stage; flushes outside the drain rows never
// enter it. The line stores are one memory with one read and one write per cycle and
// need no clearing after reset. Reset clears valids, counters and the window and loads
// the default sizes. A held result stalls the stages behind it only once they are full.
`default_nettype none

module median_filter_3x3_rgb
   import mf3rgb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  req_payload_type         req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_payload_type         rsp_payload,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]   csr_data
);

   logic [CFG_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [CFG_W-1:0] wm1_ff, wm1_in, hm1_ff, hm1_in;
   logic [CFG_W-1:0] sat_width, sat_height;
   logic [CNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [CNT_W-1:0] orow, ocol, col_inc;
   logic             csr_write, ignored, drain, col_ge1;
   item_ctl_type     s0_ctl;
   pixel_type        s0_px;

   logic free1, free2, free3, free4;
   logic accept, ld1, mv1, ld2, ld3, ld4;

   logic              s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0] s1_addr_ff;
   pixel_type         s1_px_ff;
   item_ctl_type      s1_ctl_ff;
   line_pair_type     rd_data, wr_data;

   pixel_type [WIN_SIZE-1:0][WIN_SIZE-1:0] window_ff, window_in;
   taps_type [NUM_CHAN-1:0] lane_taps;
   lane_results_type        lane_res;
   lane_ctl_type            lane_ctl;

   logic         s2_valid_ff, s2_valid_in, s3_valid_ff, s3_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   pixel_type    s2_center_ff, s3_center_ff;
   item_ctl_type s2_ctl_ff, s3_ctl_ff;

   // Configuration registers, kept already saturated.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      sat_width  = csr_data;
      sat_height = csr_data;
      if (csr_data < MIN_SIZE) begin
         sat_width  = MIN_SIZE;
         sat_height = MIN_SIZE;
      end else if (csr_data > WIDTH_LIMIT) begin
         sat_width = WIDTH_LIMIT;
      end
      width_in  = width_ff;
      height_in = height_ff;
      wm1_in    = wm1_ff;
      hm1_in    = hm1_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = sat_width;
               wm1_in   = sat_width - CFG_W'(1);
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = sat_height;
               hm1_in    = sat_height - CFG_W'(1);
            end
            default: begin
            end
         endcase
      end
   end

   // Position of the window center and the flags of the result it produces.
   always_comb begin
      drain   = (row_ff >= height_ff);
      ignored = req_payload.action && !drain;
      col_ge1 = (col_ff != '0);
      orow    = col_ge1 ? row_ff - CNT_W'(1) : row_ff - CNT_W'(2);
      ocol    = col_ge1 ? col_ff - CNT_W'(1) : wm1_ff;
      s0_ctl.emit   = col_ge1 ? (row_ff >= CNT_W'(1)) : (row_ff >= CNT_W'(2));
      s0_ctl.border = (orow == '0) || (orow >= hm1_ff) || (ocol == '0) || (ocol >= wm1_ff);
      s0_ctl.eol    = (ocol == wm1_ff);
      s0_ctl.eof    = s0_ctl.emit && s0_ctl.eol && (orow == hm1_ff);
      s0_px = (req_payload.action || drain) ? '0
            : {req_payload.red_in, req_payload.green_in, req_payload.blue_in};
      col_inc = col_ff + CNT_W'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (csr_write && (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT)) begin
         col_in = '0;
         row_in = '0;
      end else if (ld1) begin
         if (s0_ctl.eof) begin
            col_in = '0;
            row_in = '0;
         end else if (col_inc >= width_ff) begin
            col_in = '0;
            row_in = row_ff + CNT_W'(1);
         end else begin
            col_in = col_inc;
         end
      end
   end

   // Stage handshakes; a stage takes a new request once it is empty or moving on.
   assign free4 = !rsp_valid_ff || !rsp_stall;
   assign free3 = !s3_valid_ff || free4;
   assign free2 = !s2_valid_ff || free3;
   assign free1 = !s1_valid_ff || !s1_ctl_ff.emit || free2;
   assign req_stall = !free1;
   assign accept = req_valid && free1;
   assign ld1 = accept && !ignored;
   assign mv1 = s1_valid_ff && (!s1_ctl_ff.emit || free2);
   assign ld2 = s1_valid_ff && s1_ctl_ff.emit && free2;
   assign ld3 = s2_valid_ff && free3;
   assign ld4 = s3_valid_ff && free4;

   assign s1_valid_in  = free1 ? ld1 : s1_valid_ff;
   assign s2_valid_in  = free2 ? ld2 : s2_valid_ff;
   assign s3_valid_in  = free3 ? ld3 : s3_valid_ff;
   assign rsp_valid_in = free4 ? ld4 : rsp_valid_ff;

   assign wr_data.upper = rd_data.lower;
   assign wr_data.lower = s1_px_ff;

   mf3rgb_line_buf u_line_buf (
      .clock   (clock),
      .rd_en   (ld1),
      .rd_addr (col_ff[ADDR_W-1:0]),
      .rd_data (rd_data),
      .wr_en   (mv1),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data)
   );

   always_comb begin
      for (int r = 0; r < WIN_SIZE; r++) begin
         for (int c = 0; c < WIN_SIZE - 1; c++) begin
            window_in[r][c] = window_ff[r][c + 1];
         end
      end
      window_in[0][WIN_SIZE-1] = rd_data.upper;
      window_in[1][WIN_SIZE-1] = rd_data.lower;
      window_in[2][WIN_SIZE-1] = s1_px_ff;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         for (int r = 0; r < WIN_SIZE; r++) begin
            for (int c = 0; c < WIN_SIZE; c++) begin
               lane_taps[ch][r * WIN_SIZE + c] = window_in[r][c][ch];
            end
         end
      end
   end

   assign lane_ctl.load_sort   = ld2;
   assign lane_ctl.load_reduce = ld3;

   for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_lane
      mf3rgb_lane u_lane (
         .clock  (clock),
         .ctl    (lane_ctl),
         .taps   (lane_taps[ch]),
         .result (lane_res[ch])
      );
   end

   mf3rgb_merge u_merge (
      .clock   (clock),
      .load    (ld4),
      .lanes   (lane_res),
      .center  (s3_center_ff),
      .ctl     (s3_ctl_ff),
      .payload (rsp_payload)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         wm1_ff       <= WIDTH_RESET - CFG_W'(1);
         hm1_ff       <= HEIGHT_RESET - CFG_W'(1);
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= '0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         wm1_ff       <= wm1_in;
         hm1_ff       <= hm1_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mv1) begin
            window_ff <= window_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_addr_ff <= col_ff[ADDR_W-1:0];
         s1_px_ff   <= s0_px;
         s1_ctl_ff  <= s0_ctl;
      end
      if (ld2) begin
         s2_center_ff <= window_in[1][1];
         s2_ctl_ff    <= s1_ctl_ff;
      end
      if (ld3) begin
         s3_center_ff <= s2_center_ff;
         s3_ctl_ff    <= s2_ctl_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_col_in_line: assert property (@(posedge clock) disable iff (reset)
      col_ff < width_ff)
      else $error("Column counter reached the line width.");

   a_eof_restarts: assert property (@(posedge clock) disable iff (reset)
      (ld1 && s0_ctl.eof) |=> (col_ff == '0 && row_ff == '0))
      else $error("Counters did not restart after the end of the frame.");

   a_eof_ends_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.end_of_frame) |-> rsp_payload.end_of_line)
      else $error("End of frame given without end of line.");
`endif

endmodule

`default_nettype wire

/* dv/median_filter_3x3_rgb_tb.sv */
// Self-checking testbench for the 3x3 RGB median filter with a built-in pixel predictor.
module median_filter_3x3_rgb_tb;
   import mf3rgb_pkg::*;

   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_UNUSED  = '1;
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 4000;
   localparam int PRINT_LIMIT   = 100;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [CFG_W-1:0]     csr_data    = '0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   int unsigned      col_pos;
   int unsigned      row_pos;
   bit [23:0]        upper_line [MAX_WIDTH];
   bit [23:0]        lower_line [MAX_WIDTH];
   bit [23:0]        taps [WIN_SIZE][WIN_SIZE];
   rsp_payload_type  pending_pixels [$];

   int unsigned error_count    = 0;
   int unsigned requests_taken = 0;
   int unsigned pixels_checked = 0;
   int unsigned frames_done    = 0;
   int unsigned size_writes    = 0;
   int unsigned quiet_cycles   = 0;

   median_filter_3x3_rgb dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function automatic bit [7:0] channel_middle(int lsb);
      bit [7:0] v [9];
      int i, j, below, not_above;
      for (i = 0; i < 9; i++) v[i] = taps[i / 3][i % 3][lsb +: 8];
      for (i = 0; i < 9; i++) begin
         below = 0;
         not_above = 0;
         for (j = 0; j < 9; j++) begin
            if (v[j] < v[i]) below++;
            if (v[j] <= v[i]) not_above++;
         end
         if (below <= 4 && not_above >= 5) return v[i];
      end
      return v[4];
   endfunction

   task automatic filter_step(input req_payload_type item);
      int unsigned w, h, c, r, orow, ocol, k;
      bit emit;
      bit [23:0] px, up, lo, res;
      rsp_payload_type want;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = height_reg;
      if (h < 3) h = 3;
      c = col_pos;
      r = row_pos;
      if (item.action == ACT_FLUSH && r < h) return;
      px = (item.action == ACT_FLUSH) ? 24'h0
                                      : {item.red_in, item.green_in, item.blue_in};
      up = upper_line[c];
      lo = lower_line[c];
      upper_line[c] = lo;
      lower_line[c] = px;
      for (k = 0; k < WIN_SIZE; k++) begin
         taps[k][0] = taps[k][1];
         taps[k][1] = taps[k][2];
      end
      taps[0][2] = up;
      taps[1][2] = lo;
      taps[2][2] = px;
      if (c >= 1) begin
         emit = (r >= 1);
         orow = r - 1;
         ocol = c - 1;
      end else begin
         emit = (r >= 2);
         orow = r - 2;
         ocol = w - 1;
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      col_pos = c;
      row_pos = r % 4096;
      if (!emit) return;
      if (orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1) begin
         res = taps[1][1];
      end else begin
         res = {channel_middle(16), channel_middle(8), channel_middle(0)};
      end
      want.red_out      = res[23:16];
      want.green_out    = res[15:8];
      want.blue_out     = res[7:0];
      want.end_of_line  = (ocol == w - 1);
      want.end_of_frame = want.end_of_line && (orow == h - 1);
      if (want.end_of_frame) begin
         col_pos = 0;
         row_pos = 0;
      end
      pending_pixels = {pending_pixels, want};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         col_pos    = 0;
         row_pos    = 0;
         foreach (taps[i, j]) taps[i][j] = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            size_writes++;
            if (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT) begin
               if (csr_index == CSR_IMAGE_WIDTH) width_reg = csr_data;
               else height_reg = csr_data;
               col_pos = 0;
               row_pos = 0;
            end
         end
         if (req_valid && !req_stall) begin
            requests_taken++;
            filter_step(req_payload);
         end
      end
   end

   task automatic report_error(input string what);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            report_error($sformatf("result %h arrived with nothing pending", rsp_payload));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_payload.red_out !== want.red_out)
               report_error($sformatf("result %0d red_out %0d, expected %0d",
                                      pixels_checked, rsp_payload.red_out, want.red_out));
            if (rsp_payload.green_out !== want.green_out)
               report_error($sformatf("result %0d green_out %0d, expected %0d",
                                      pixels_checked, rsp_payload.green_out, want.green_out));
            if (rsp_payload.blue_out !== want.blue_out)
               report_error($sformatf("result %0d blue_out %0d, expected %0d",
                                      pixels_checked, rsp_payload.blue_out, want.blue_out));
            if (rsp_payload.end_of_line !== want.end_of_line)
               report_error($sformatf("result %0d end_of_line %b, expected %b", pixels_checked,
                                      rsp_payload.end_of_line, want.end_of_line));
            if (rsp_payload.end_of_frame !== want.end_of_frame)
               report_error($sformatf("result %0d end_of_frame %b, expected %b", pixels_checked,
                                      rsp_payload.end_of_frame, want.end_of_frame));
            if (want.end_of_frame) frames_done++;
            pixels_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending_pixels.size());
         $display("FAIL median_filter_3x3_rgb");
         $finish;
      end
   end

   function automatic bit [23:0] random_pixel();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return {($urandom_range(1) ? 8'hFF : 8'h00), ($urandom_range(1) ? 8'hFF : 8'h00),
                    ($urandom_range(1) ? 8'hFF : 8'h00)};
         2: return {8'($urandom_range(3)), 8'($urandom_range(3)), 8'($urandom_range(3))};
         default: return {8'($urandom_range(120, 135)), 8'($urandom_range(120, 135)),
                          8'($urandom_range(120, 135))};
      endcase
   endfunction

   task automatic send_request(input logic action, input bit [23:0] px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid   <= 1'b0;
         req_payload <= {1'($urandom_range(1)), 24'($urandom)};
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= {action, px};
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic send_pixels(input int unsigned count, input int unsigned flush_pct);
      int unsigned i;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(99) < flush_pct) send_request(ACT_FLUSH, 24'($urandom));
         send_request(ACT_PIXEL, random_pixel());
      end
   endtask

   task automatic send_drain(input int unsigned count, input int unsigned pixel_pct);
      int unsigned i;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(99) < pixel_pct) send_request(ACT_PIXEL, random_pixel());
         else send_request(ACT_FLUSH, 24'($urandom));
      end
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      settle_block();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_sizes();
      send_pixels(645, 5);
   endtask

   task automatic test_directed_frame();
      bit [23:0] grid [9];
      int unsigned i;
      grid = '{24'h000000, 24'hFFFFFF, 24'h102030, 24'hFF00FF, 24'h7F807F,
               24'h00FF00, 24'h010203, 24'hFEFDFC, 24'h808080};
      write_register(CSR_IMAGE_WIDTH, CFG_W'(3));
      write_register(CSR_IMAGE_HEIGHT, CFG_W'(3));
      send_request(ACT_FLUSH, 24'hFFFFFF);
      for (i = 0; i < 9; i++) begin
         send_request(ACT_PIXEL, grid[i]);
         if (i == 4) send_request(ACT_FLUSH, 24'h000000);
      end
      send_request(ACT_PIXEL, 24'hABCDEF);
      send_request(ACT_FLUSH, 24'h000000);
      send_request(ACT_PIXEL, 24'h123456);
      send_request(ACT_FLUSH, 24'h000000);
      send_request(ACT_FLUSH, 24'hFFFFFF);
   endtask

   task automatic test_register_rules();
      write_register(CSR_IMAGE_WIDTH, '0);
      write_register(CSR_IMAGE_HEIGHT, CFG_W'(1));
      send_pixels(4, 0);
      write_register(CSR_LAST_UNUSED, '1);
      send_pixels(5, 0);
      send_drain(4, 50);
      write_register(CSR_IMAGE_WIDTH, CFG_W'(5));
      write_register(CSR_IMAGE_HEIGHT, '1);
      send_pixels(13, 0);
   endtask

   task automatic test_random_frames(input int unsigned target);
      int unsigned counted, w, h, frames, f, n, cut, sel;
      logic [CFG_W-1:0] wval, hval;
      counted = 0;
      while (counted < target) begin
         sel = $urandom_range(99);
         if (sel < 10) w = 3;
         else if (sel < 85) w = $urandom_range(3, 10);
         else w = $urandom_range(11, 40);
         sel = $urandom_range(99);
         if (sel < 15) h = 3;
         else if (sel < 85) h = $urandom_range(3, 6);
         else h = $urandom_range(7, 14);
         wval = (w == 3 && $urandom_range(1)) ? CFG_W'($urandom_range(3)) : CFG_W'(w);
         hval = (h == 3 && $urandom_range(1)) ? CFG_W'($urandom_range(3)) : CFG_W'(h);
         if ($urandom_range(1)) begin
            write_register(CSR_IMAGE_WIDTH, wval);
            write_register(CSR_IMAGE_HEIGHT, hval);
         end else begin
            write_register(CSR_IMAGE_HEIGHT, hval);
            write_register(CSR_IMAGE_WIDTH, wval);
         end
         frames = $urandom_range(1, 3);
         for (f = 0; f < frames; f++) begin
            n = w * h;
            sel = $urandom_range(99);
            if (sel < 15) begin
               cut = $urandom_range(1, n - 1);
               send_pixels(cut, $urandom_range(15));
               counted += cut;
               break;
            end else if (sel < 25) begin
               cut = $urandom_range(1, n - 1);
               send_pixels(cut, $urandom_range(15));
               write_register(CSR_IDX_W'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_UNUSED)),
                              CFG_W'($urandom));
               send_pixels(n - cut, $urandom_range(15));
            end else begin
               send_pixels(n, $urandom_range(15));
            end
            send_drain(w + 1, $urandom_range(100));
            counted += n + w + 1;
            if ($urandom_range(3) == 0) send_drain($urandom_range(1, 2), 0);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 16;
      recv_idle_pct = 82;
      test_reset_sizes();
      test_directed_frame();
      test_register_rules();
      test_random_frames(360);

      send_idle_pct = 82;
      recv_idle_pct = 16;
      test_random_frames(360);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(360);

      settle_block();
      $display("Covered %0d requests, %0d checked results, %0d whole frames, %0d register writes.",
               requests_taken, pixels_checked, frames_done, size_writes);
      $display("Whole frames ran 3 to 40 pixels wide; the reset width and 4095 lines also ran.");
      if (error_count == 0) begin
         $display("PASS median_filter_3x3_rgb");
      end else begin
         $display("FAIL median_filter_3x3_rgb");
      end
      $finish;
   end

endmodule
